// ===== rtl/core/wsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, chunk identifiers and codes of the WAV stream parser.
// No dependencies; every other file of the block but wsp_if imports this package.
package wsp_pkg;

	// Four-character chunk identifiers as they read little-endian from the file.
	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	// Format values that the fmt chunk must declare, and the fmt body length that is always read.
	localparam logic [15:0] FMT_PCM      = 16'd1;
	localparam logic [15:0] FMT_CHANNELS = 16'd2;
	localparam logic [15:0] FMT_BITS     = 16'd16;
	localparam logic [31:0] FMT_BODY_LEN = 32'd16;

	// Reset value of the required sample rate register.
	localparam logic [31:0] RATE_RESET = 32'd44100;

	// Configuration port geometry: one 32-bit register at byte address 0.
	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-3:0] REG_RATE = '0;

	// Result kinds.
	localparam logic KIND_FRAME   = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Verdict error codes.
	localparam logic [1:0] ERR_BAD_HEADER = 2'd0;
	localparam logic [1:0] ERR_BAD_FMT    = 2'd1;
	localparam logic [1:0] ERR_ORDER      = 2'd2;
	localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

	// Result queue geometry. An item may push two results, so the input side
	// needs two free entries.
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               verdict_ok;
		logic [1:0]         error_code;
	} result_t;

	// Results produced by one accepted item, in delivery order.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	typedef struct packed {
		logic done;
	} core_status_t;

endpackage

// ===== rtl/core/wsp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces of the WAV stream parser: file bytes in, results out.
// Depends on nothing; payload widths follow the block's field list.
interface wsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_file;
	logic       end_of_file;

	modport source (output valid, data_byte, start_of_file, end_of_file, input ready);
	modport sink (input valid, data_byte, start_of_file, end_of_file, output ready);
endinterface

interface wsp_out_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [15:0] left;
	logic signed [15:0] right;
	logic               verdict_ok;
	logic [1:0]         error_code;

	modport source (output valid, kind, left, right, verdict_ok, error_code, input ready);
	modport sink (input valid, kind, left, right, verdict_ok, error_code, output ready);
endinterface

// ===== rtl/core/wsp_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration register holding the required sample rate.
// Depends on wsp_pkg.
module wsp_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wsp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [31:0]                 required_rate
);
	import wsp_pkg::*;

	logic [31:0] rate_q;
	logic        hit;

	// The low two address bits select a byte within the word and are ignored.
	assign hit    = (paddr[PADDR_W-1:2] == REG_RATE);
	assign pready = 1'b1;
	assign prdata = hit ? rate_q : 32'd0;
	assign required_rate = rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (psel && penable && pwrite && hit) begin
			rate_q <= pwdata;
		end
	end

endmodule

// ===== rtl/core/wsp_parser_core.sv =====
`timescale 1ns / 1ps
// Byte-wise RIFF/WAVE parser state: header check, chunk walk, fmt check, frame assembly.
// Depends on wsp_pkg; feeds its results to wsp_out_queue.
module wsp_parser_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  wsp_pkg::in_item_t     item,
	input  logic [31:0]           required_rate,
	output wsp_pkg::push_t        push,
	output wsp_pkg::core_status_t status
);
	import wsp_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR,
		PH_CHDR,
		PH_FMT,
		PH_SKIP,
		PH_PAD,
		PH_DATA,
		PH_DONE
	} phase_t;

	phase_t      phase_q, ph, ph_n;
	logic [31:0] count_q, cnt, cnt_n;
	logic [31:0] id_q, id, id_n;
	logic [31:0] size_q, sz, sz_n;
	logic [63:0] fmt_q, fmt, fmt_n;
	logic        seen_q, seen, seen_n;
	logic [29:0] frames_q, frames, frames_n;
	logic [23:0] part_q, part, part_n;
	push_t       res;

	logic [7:0]  b;
	logic [1:0]  lane;
	logic [3:0]  fi;
	logic        fmt_bad;
	logic [31:0] skip_len;
	logic [31:0] skip_left;

	function automatic result_t make_verdict(input logic ok, input logic [1:0] code);
		result_t r;
		r.kind       = KIND_VERDICT;
		r.left       = '0;
		r.right      = '0;
		r.verdict_ok = ok;
		r.error_code = ok ? ERR_BAD_HEADER : code;
		return r;
	endfunction

	assign b = item.data_byte;

	always_comb begin
		// A start mark clears the parse state before the byte is looked at.
		if (item.start_of_file) begin
			ph     = PH_HDR;
			cnt    = '0;
			id     = '0;
			sz     = '0;
			fmt    = '0;
			seen   = 1'b0;
			frames = '0;
			part   = '0;
		end else begin
			ph     = phase_q;
			cnt    = count_q;
			id     = id_q;
			sz     = size_q;
			fmt    = fmt_q;
			seen   = seen_q;
			frames = frames_q;
			part   = part_q;
		end

		lane = cnt[1:0];
		fi   = cnt[3:0];

		ph_n     = ph;
		cnt_n    = cnt;
		id_n     = id;
		sz_n     = sz;
		fmt_n    = fmt;
		seen_n   = seen;
		frames_n = frames;
		part_n   = part;
		res      = '0;
		fmt_bad  = 1'b0;
		skip_len  = '0;
		skip_left = '0;

		if (item.end_of_file) begin
			if (ph != PH_DONE) begin
				res.count = 2'd1;
				res.first = make_verdict(1'b0, ERR_TRUNCATED);
				ph_n      = PH_DONE;
			end
		end else begin
			unique case (ph)
				PH_HDR: begin
					if (cnt < 32'd4 || cnt >= 32'd8) begin
						if (lane == 2'd0) begin
							id_n = '0;
						end
						id_n[{lane, 3'b000} +: 8] = id_n[{lane, 3'b000} +: 8] | b;
					end
					// A wrong RIFF tag is remembered until the whole header is in.
					if (cnt == 32'd3 && id_n != ID_RIFF) begin
						sz_n = 32'd1;
					end
					if (cnt == 32'd11) begin
						if (sz_n != 32'd0 || id_n != ID_WAVE) begin
							res.count = 2'd1;
							res.first = make_verdict(1'b0, ERR_BAD_HEADER);
							ph_n      = PH_DONE;
						end else begin
							sz_n  = '0;
							cnt_n = '0;
							ph_n  = PH_CHDR;
						end
					end else begin
						cnt_n = cnt + 32'd1;
					end
				end

				PH_CHDR: begin
					if (cnt < 32'd4) begin
						if (lane == 2'd0) begin
							id_n = '0;
						end
						id_n[{lane, 3'b000} +: 8] = id_n[{lane, 3'b000} +: 8] | b;
						cnt_n = cnt + 32'd1;
					end else begin
						if (lane == 2'd0) begin
							sz_n = '0;
						end
						sz_n[{lane, 3'b000} +: 8] = sz_n[{lane, 3'b000} +: 8] | b;
						if (cnt < 32'd7) begin
							cnt_n = cnt + 32'd1;
						end else if (id == ID_FMT) begin
							fmt_n = '0;
							cnt_n = '0;
							ph_n  = PH_FMT;
						end else if (id == ID_DATA) begin
							if (!seen) begin
								res.count = 2'd1;
								res.first = make_verdict(1'b0, ERR_ORDER);
								ph_n      = PH_DONE;
							end else begin
								frames_n = sz_n[31:2];
								cnt_n    = '0;
								part_n   = '0;
								if (sz_n[31:2] == 30'd0) begin
									res.count = 2'd1;
									res.first = make_verdict(1'b1, ERR_BAD_HEADER);
									ph_n      = PH_DONE;
								end else begin
									ph_n = PH_DATA;
								end
							end
						end else if (sz_n == 32'd0) begin
							cnt_n = '0;
							ph_n  = PH_CHDR;
						end else begin
							cnt_n = sz_n;
							ph_n  = PH_SKIP;
						end
					end
				end

				PH_FMT: begin
					if (fi < 4'd8) begin
						fmt_n[{fi[2:0], 3'b000} +: 8] = fmt_n[{fi[2:0], 3'b000} +: 8] | b;
					end
					// Format, channels and rate collapse into one sticky flag in bit 63.
					if (fi == 4'd7) begin
						fmt_bad = (fmt_n[15:0] != FMT_PCM) || (fmt_n[31:16] != FMT_CHANNELS)
							|| (fmt_n[63:32] != required_rate);
						fmt_n = fmt_bad ? {1'b1, 63'd0} : 64'd0;
					end
					if (fi >= 4'd14) begin
						fmt_n[{fi[0], 3'b000} +: 8] = fmt_n[{fi[0], 3'b000} +: 8] | b;
					end
					if (fi == 4'd15) begin
						if (fmt_n[63] || fmt_n[15:0] != FMT_BITS) begin
							res.count = 2'd1;
							res.first = make_verdict(1'b0, ERR_BAD_FMT);
							ph_n      = PH_DONE;
						end else begin
							seen_n   = 1'b1;
							skip_len = (sz > FMT_BODY_LEN) ? (sz - FMT_BODY_LEN) : 32'd0;
							if (skip_len == 32'd0) begin
								cnt_n = '0;
								ph_n  = sz[0] ? PH_PAD : PH_CHDR;
							end else begin
								cnt_n = skip_len;
								ph_n  = PH_SKIP;
							end
						end
					end else begin
						cnt_n = cnt + 32'd1;
					end
				end

				PH_SKIP: begin
					skip_left = cnt - 32'd1;
					cnt_n     = skip_left;
					if (skip_left == 32'd0) begin
						ph_n = sz[0] ? PH_PAD : PH_CHDR;
					end
				end

				PH_PAD: begin
					cnt_n = '0;
					ph_n  = PH_CHDR;
				end

				PH_DATA: begin
					if (lane != 2'd3) begin
						if (lane == 2'd0) begin
							part_n = '0;
						end
						part_n[{lane, 3'b000} +: 8] = part_n[{lane, 3'b000} +: 8] | b;
						cnt_n = cnt + 32'd1;
					end else begin
						res.count            = 2'd1;
						res.first.kind       = KIND_FRAME;
						res.first.left       = part[15:0];
						res.first.right      = {b, part[23:16]};
						res.first.verdict_ok = 1'b0;
						res.first.error_code = ERR_BAD_HEADER;
						cnt_n    = '0;
						frames_n = frames - 30'd1;
						if (frames_n == 30'd0) begin
							res.count  = 2'd2;
							res.second = make_verdict(1'b1, ERR_BAD_HEADER);
							ph_n       = PH_DONE;
						end
					end
				end

				PH_DONE: begin
				end

				default: begin
				end
			endcase
		end

		if (!accept) begin
			res.count = 2'd0;
		end
	end

	assign push        = res;
	assign status.done = (phase_q == PH_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			count_q  <= '0;
			id_q     <= '0;
			size_q   <= '0;
			fmt_q    <= '0;
			seen_q   <= 1'b0;
			frames_q <= '0;
			part_q   <= '0;
		end else if (accept) begin
			phase_q  <= ph_n;
			count_q  <= cnt_n;
			id_q     <= id_n;
			size_q   <= sz_n;
			fmt_q    <= fmt_n;
			seen_q   <= seen_n;
			frames_q <= frames_n;
			part_q   <= part_n;
		end
	end

endmodule

// ===== rtl/core/wsp_out_queue.sv =====
`timescale 1ns / 1ps
// Small result queue that takes up to two results a cycle and delivers one.
// Depends on wsp_pkg and wsp_out_if.
module wsp_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  wsp_pkg::push_t   push,
	output logic             has_room,
	wsp_out_if.source        res
);
	import wsp_pkg::*;

	result_t              mem [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 pop;
	result_t              head;

	assign pop      = res.valid && res.ready;
	assign has_room = (cnt_q <= Q_CNT_W'(Q_DEPTH - 2));
	assign head     = mem[rd_ptr_q];

	assign res.valid      = (cnt_q != '0);
	assign res.kind       = head.kind;
	assign res.left       = head.left;
	assign res.right      = head.right;
	assign res.verdict_ok = head.verdict_ok;
	assign res.error_code = head.error_code;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wr_ptr_q + Q_PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + Q_PTR_W'(pop);
			cnt_q    <= cnt_q + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/core/wav_stream_parser.sv =====
`timescale 1ns / 1ps
// Top level of the WAV stream parser: configuration register, parser core, result queue.
// Depends on wsp_pkg, wsp_if, wsp_cfg_regs, wsp_parser_core and wsp_out_queue.
//
//   Channel     Direction  Payload                                    Transfer
//   file_bytes  in         data_byte, start_of_file, end_of_file      valid && ready
//   samples     out        kind, left, right, verdict_ok, error_code  valid && ready
//   APB         in/out     required_rate at byte address 0            psel&penable&pwrite
//
// One file byte is taken per cycle while file_bytes.ready is high; the parser state
// updates at the edge of the transfer and the results it causes enter the result queue
// at that same edge, and a frame or verdict is offered once earlier results have left.
// The last frame and its success verdict leave the queue on two consecutive transfers.
// file_bytes.ready drops only while fewer than two queue entries are free, which
// happens only when the sink of samples stalls.
// Reset (arst_n low) puts the parser in front of a file header and sets the rate to 44100.
module wav_stream_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	wsp_in_if.sink                      file_bytes,
	wsp_out_if.source                   samples,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wsp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import wsp_pkg::*;

	logic         accept;
	logic         has_room;
	logic [31:0]  required_rate;
	in_item_t     item;
	push_t        push;
	core_status_t status;

	// The user writes the configuration register only while the stream is idle; the block does not enforce this.
	wsp_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.required_rate (required_rate)
	);

	assign file_bytes.ready = has_room;
	assign accept           = file_bytes.valid && file_bytes.ready;

	assign item.data_byte     = file_bytes.data_byte;
	assign item.start_of_file = file_bytes.start_of_file;
	assign item.end_of_file   = file_bytes.end_of_file;

	// The core decides, for each accepted byte, the next parse state and the
	// zero, one or two results that the byte causes.
	wsp_parser_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.item          (item),
		.required_rate (required_rate),
		.push          (push),
		.status        (status)
	);

	// The queue decouples the two sides so bytes keep flowing while a result waits.
	wsp_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.has_room (has_room),
		.res      (samples)
	);

	// Two results from one byte are always the last frame followed by success.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> push.first.kind == KIND_FRAME
			&& push.second.kind == KIND_VERDICT && push.second.verdict_ok)
		else $error("two results from one byte are not frame then success");

	// Any verdict leaves the parser finished.
	a_verdict_done: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2 || (push.count == 2'd1 && push.first.kind == KIND_VERDICT))
			|=> status.done)
		else $error("parser not finished after a verdict");

	// Frames carry neither a verdict flag nor an error code.
	a_frame_clean: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.kind == KIND_FRAME
			|-> !samples.verdict_ok && samples.error_code == ERR_BAD_HEADER)
		else $error("frame result carries verdict fields");

	// Back-pressure on bytes only comes from results piling up.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!file_bytes.ready |-> samples.valid)
		else $error("byte input stalled with no result waiting");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench of wav_stream_parser: WAV byte streams go in, frames and verdicts are checked.
// Depends on wsp_pkg, wsp_if and the parser RTL; expected results come from a built-in predictor.
module tb;
	import wsp_pkg::*;

	// A stream that makes no transfer for this many cycles counts as hung.
	localparam int unsigned STALL_LIMIT  = 2000;
	// Length of the deliberate output hold-off that fills the result queue.
	localparam int unsigned HOLD_CYCLES  = 300;
	// Number of file bytes after which the random part starts no further file.
	localparam int unsigned RANDOM_BYTES = 600;
	// Byte address of the required rate register.
	localparam logic [PADDR_W-1:0] RATE_ADDR = {REG_RATE, 2'b00};

	// Phases of the predictor, following the walk through a RIFF file.
	typedef enum logic [2:0] {
		PH_HEADER, PH_CHUNK, PH_FMT, PH_SKIP, PH_PAD, PH_DATA, PH_DONE
	} parse_phase_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	wsp_in_if file_bytes ();
	wsp_out_if samples ();

	wav_stream_parser u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_bytes (file_bytes),
		.samples    (samples),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #1 clk = ~clk;

	// Frames and verdicts that the predictor has announced and the block has not yet sent.
	result_t results_due[$];
	// The file being sent, one byte per entry.
	logic [7:0] wav_q[$];

	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned quiet_cycles = 0;
	bit src_calm = 1'b0;
	bit snk_calm = 1'b0;
	bit hold_req = 1'b0;

	// Predictor state: a copy of the parser's registers and of the rate register.
	logic [31:0] rate_reg;
	parse_phase_t st_phase;
	logic [31:0] st_count;
	logic [31:0] st_id;
	logic [31:0] st_size;
	logic [63:0] st_fmt;
	logic st_fmt_seen;
	logic [29:0] st_frames;
	logic [23:0] st_partial;

	// Appends one byte to the end of the file being built.
	function automatic void add_byte(input logic [7:0] v);
		wav_q.insert(wav_q.size(), v);
	endfunction

	// Appends one result to the end of the expected list.
	function automatic void add_result(input result_t r);
		results_due.insert(results_due.size(), r);
	endfunction

	function automatic void clear_parser();
		st_phase = PH_HEADER;
		st_count = '0;
		st_id = '0;
		st_size = '0;
		st_fmt = '0;
		st_fmt_seen = 1'b0;
		st_frames = '0;
		st_partial = '0;
	endfunction

	function automatic void post_verdict(input logic ok, input logic [1:0] code);
		result_t r;
		r = '0;
		r.kind = KIND_VERDICT;
		r.verdict_ok = ok;
		if (!ok)
			r.error_code = code;
		add_result(r);
		st_phase = PH_DONE;
	endfunction

	// A chunk body has been consumed: an odd size is followed by one pad byte.
	function automatic void chunk_done();
		st_count = '0;
		st_phase = st_size[0] ? PH_PAD : PH_CHUNK;
	endfunction

	function automatic void skip_bytes(input logic [31:0] n);
		if (n == 0) begin
			chunk_done();
		end else begin
			st_count = n;
			st_phase = PH_SKIP;
		end
	endfunction

	// Advances the predictor by one accepted transfer and queues the results it causes.
	function automatic void parse_byte(input logic [7:0] b, input logic sof, input logic eof);
		int unsigned sh;
		int unsigned idx;
		logic bad;
		result_t r;
		if (sof)
			clear_parser();
		// An end mark before the verdict means the file was cut short.
		if (eof) begin
			if (st_phase != PH_DONE)
				post_verdict(1'b0, ERR_TRUNCATED);
			return;
		end
		sh = st_count[1:0];
		case (st_phase)
			PH_HEADER: begin
				// Bytes 4..7 hold the RIFF size, which nobody checks.
				if (st_count < 4 || st_count >= 8) begin
					if (sh == 0)
						st_id = '0;
					st_id |= {24'b0, b} << (8 * sh);
				end
				// A wrong RIFF tag is remembered and judged with the rest of the header.
				if (st_count == 3 && st_id != ID_RIFF)
					st_size = 32'd1;
				if (st_count == 11) begin
					if (st_size != 0 || st_id != ID_WAVE) begin
						post_verdict(1'b0, ERR_BAD_HEADER);
					end else begin
						st_size = '0;
						st_count = '0;
						st_phase = PH_CHUNK;
					end
				end else begin
					st_count++;
				end
			end
			PH_CHUNK: begin
				if (st_count < 4) begin
					if (sh == 0)
						st_id = '0;
					st_id |= {24'b0, b} << (8 * sh);
					st_count++;
				end else begin
					if (sh == 0)
						st_size = '0;
					st_size |= {24'b0, b} << (8 * sh);
					if (st_count < 7) begin
						st_count++;
					end else if (st_id == ID_FMT) begin
						st_fmt = '0;
						st_count = '0;
						st_phase = PH_FMT;
					end else if (st_id == ID_DATA) begin
						if (!st_fmt_seen) begin
							post_verdict(1'b0, ERR_ORDER);
						end else begin
							st_frames = st_size[31:2];
							st_count = '0;
							st_partial = '0;
							if (st_frames == 0)
								post_verdict(1'b1, ERR_BAD_HEADER);
							else
								st_phase = PH_DATA;
						end
					end else begin
						skip_bytes(st_size);
					end
				end
			end
			PH_FMT: begin
				// Sixteen body bytes are always read; only format, channels, rate and
				// bits matter, and the first three are folded into one flag at byte 7.
				idx = st_count[3:0];
				if (idx < 8)
					st_fmt |= {56'b0, b} << (8 * idx);
				if (idx == 7) begin
					bad = st_fmt[15:0] != FMT_PCM || st_fmt[31:16] != FMT_CHANNELS ||
						st_fmt[63:32] != rate_reg;
					st_fmt = bad ? 64'h8000_0000_0000_0000 : 64'h0;
				end
				if (idx >= 14)
					st_fmt |= {56'b0, b} << (8 * (idx - 14));
				if (idx == 15) begin
					bad = st_fmt[63] || st_fmt[15:0] != FMT_BITS;
					if (bad) begin
						post_verdict(1'b0, ERR_BAD_FMT);
					end else begin
						st_fmt_seen = 1'b1;
						skip_bytes(st_size > FMT_BODY_LEN ? st_size - FMT_BODY_LEN : 32'd0);
					end
				end else begin
					st_count++;
				end
			end
			PH_SKIP: begin
				st_count--;
				if (st_count == 0)
					chunk_done();
			end
			PH_PAD: begin
				st_count = '0;
				st_phase = PH_CHUNK;
			end
			PH_DATA: begin
				if (sh < 3) begin
					if (sh == 0)
						st_partial = '0;
					st_partial |= {16'b0, b} << (8 * sh);
					st_count++;
				end else begin
					r = '0;
					r.kind = KIND_FRAME;
					r.left = st_partial[15:0];
					r.right = {b, st_partial[23:16]};
					add_result(r);
					st_count = '0;
					st_frames = st_frames - 1'b1;
					// The last frame and the success verdict come from the same byte.
					if (st_frames == 0)
						post_verdict(1'b1, ERR_BAD_HEADER);
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 2);
		else if (r < 97)
			return $urandom_range(3, 8);
		else
			return $urandom_range(15, 40);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Samples lean toward the extremes of the Q1.15 range.
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic void put_half(input logic [15:0] h);
		add_byte(h[7:0]);
		add_byte(h[15:8]);
	endfunction

	function automatic void put_word(input logic [31:0] w);
		put_half(w[15:0]);
		put_half(w[31:16]);
	endfunction

	// A chunk the parser does not know, padded when its size is odd.
	function automatic void put_junk();
		logic [31:0] id;
		int unsigned sz;
		id = $urandom;
		if (id == ID_FMT || id == ID_DATA)
			id ^= 32'h1;
		sz = $urandom_range(0, 9);
		put_word(id);
		put_word(sz);
		repeat (sz + sz % 2) add_byte(rand_byte());
	endfunction

	// A fmt chunk; its size may be short, long or odd, and unless clean one field may be off.
	function automatic void put_fmt(input bit clean);
		int unsigned sz;
		logic [15:0] fmt;
		logic [15:0] chans;
		logic [15:0] bits;
		logic [31:0] rate;
		case ($urandom_range(0, 7))
			0, 1, 2, 3: sz = 16;
			4: sz = 18;
			5: sz = 15;
			6: sz = $urandom_range(0, 15);
			default: sz = $urandom_range(17, 24);
		endcase
		fmt = FMT_PCM;
		chans = FMT_CHANNELS;
		bits = FMT_BITS;
		rate = rate_reg;
		if (!clean && $urandom_range(0, 99) < 20) begin
			case ($urandom_range(0, 3))
				0: fmt ^= 16'h1 << $urandom_range(0, 15);
				1: chans ^= 16'h1 << $urandom_range(0, 15);
				2: rate ^= 32'h1 << $urandom_range(0, 31);
				default: bits ^= 16'h1 << $urandom_range(0, 15);
			endcase
		end
		put_word(ID_FMT);
		put_word(sz);
		put_half(fmt);
		put_half(chans);
		put_word(rate);
		put_word($urandom);
		put_half(16'($urandom_range(0, 65535)));
		put_half(bits);
		repeat (sz > 16 ? sz - 16 : 0) add_byte(rand_byte());
		if (sz % 2)
			add_byte(rand_byte());
	endfunction

	// Builds a file into wav_q. A clean file is always accepted; otherwise the header,
	// the chunk order or the fmt fields may be broken, and fmt may appear twice.
	function automatic void build_wav(input bit clean, input int unsigned frames);
		int unsigned pos;
		int unsigned extra;
		bit data_early;
		wav_q.delete();
		put_word(ID_RIFF);
		put_word($urandom);
		put_word(ID_WAVE);
		if (!clean && $urandom_range(0, 99) < 6) begin
			pos = $urandom_range(0, 7);
			if (pos >= 4)
				pos += 4;
			wav_q[pos] = wav_q[pos] ^ (8'h01 << $urandom_range(0, 7));
		end
		if (!clean && $urandom_range(0, 1))
			put_junk();
		data_early = !clean && $urandom_range(0, 99) < 6;
		if (!data_early) begin
			put_fmt(clean);
			if (!clean && $urandom_range(0, 99) < 12) begin
				if ($urandom_range(0, 1))
					put_junk();
				put_fmt(clean);
			end
		end
		if (!clean && $urandom_range(0, 3) == 0)
			put_junk();
		// Trailing bytes past the last whole frame are never turned into a frame.
		extra = $urandom_range(0, 3);
		put_word(ID_DATA);
		put_word(4 * frames + extra);
		repeat (frames) begin
			put_half(pick_sample());
			put_half(pick_sample());
		end
		repeat (extra + $urandom_range(0, 2)) add_byte(rand_byte());
	endfunction

	// Offers one item after a random gap (none while src_calm is set) and waits for its
	// transfer. The predictor runs at the edge where the transfer happens.
	task automatic send_item(input logic [7:0] b, input logic sof, input logic eof);
		int gap;
		gap = src_calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			file_bytes.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		file_bytes.valid <= 1'b1;
		file_bytes.data_byte <= b;
		file_bytes.start_of_file <= sof;
		file_bytes.end_of_file <= eof;
		@(posedge clk);
		while (!file_bytes.ready) @(posedge clk);
		parse_byte(b, sof, eof);
		bytes_sent++;
	endtask

	// Sends the first len bytes of wav_q, then an end mark if asked.
	task automatic send_wav(input bit with_sof, input int unsigned len, input bit tail_eof);
		for (int unsigned i = 0; i < len; i++)
			send_item(wav_q[i], with_sof && i == 0, 1'b0);
		if (tail_eof)
			send_item(rand_byte(), 1'b0, 1'b1);
	endtask

	// Stops offering and lets every expected result drain before the next phase.
	task automatic wait_idle();
		@(negedge clk);
		file_bytes.valid <= 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes the required rate and reads it back.
	task automatic set_rate(input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= RATE_ADDR;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rate_reg = v;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== rate_reg) begin
			$display("%0t ns: rate readback expected %h, got %h", $time, rate_reg, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Every result transfer is matched against the oldest expectation.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && samples.valid && samples.ready) begin
			if (results_due.size() == 0) begin
				$display("%0t ns: unexpected result, kind %b left %h right %h ok %b code %0d",
					$time, samples.kind, samples.left, samples.right, samples.verdict_ok,
					samples.error_code);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				compare_field("kind", 16'(want.kind), 16'(samples.kind));
				compare_field("left", want.left, samples.left);
				compare_field("right", want.right, samples.right);
				compare_field("verdict_ok", 16'(want.verdict_ok), 16'(samples.verdict_ok));
				compare_field("error_code", 16'(want.error_code), 16'(samples.error_code));
			end
		end
	end

	// Result receiver: random stalls, calm stretches, and on request one long hold-off
	// that it counts itself.
	initial begin : receiver
		int unsigned hold_left;
		int unsigned stall_left;
		logic rdy;
		hold_left = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				if (!snk_calm && $urandom_range(0, 9) < 3)
					stall_left = pick_gap();
			end
			samples.ready <= rdy;
		end
	end

	// Watchdog: a long run of cycles without any transfer ends the run.
	always @(posedge clk) begin
		if (arst_n && !(file_bytes.valid && file_bytes.ready) &&
			!(samples.valid && samples.ready))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// After reset the parser expects a header without any start mark. The file ends
	// with extreme samples; its last frame and the verdict come from one byte, and the
	// end mark and bytes after the verdict are ignored.
	task automatic test_no_start_mark();
		wav_q.delete();
		put_word(ID_RIFF);
		put_word(32'd44);
		put_word(ID_WAVE);
		put_word(ID_FMT);
		put_word(FMT_BODY_LEN);
		put_half(FMT_PCM);
		put_half(FMT_CHANNELS);
		put_word(rate_reg);
		put_word($urandom);
		put_half(16'd4);
		put_half(FMT_BITS);
		put_word(ID_DATA);
		put_word(32'd8);
		put_half(16'h8000);
		put_half(16'h7FFF);
		put_half(16'h0000);
		put_half(16'hFFFF);
		add_byte(8'hFF);
		add_byte(8'h00);
		send_wav(1'b0, wav_q.size(), 1'b1);
	endtask

	// Start and end on the same item restart and report truncation at once; a second
	// end mark after that verdict is ignored.
	task automatic test_start_and_end();
		send_item(rand_byte(), 1'b1, 1'b1);
		send_item(rand_byte(), 1'b0, 1'b1);
	endtask

	// A header cut short is reported as truncated, not as a bad header.
	task automatic test_short_header();
		build_wav(1'b1, 1);
		send_wav(1'b1, 5, 1'b1);
	endtask

	// Rates at both ends of the register range, each with a file that declares it.
	task automatic test_rate_extremes();
		wait_idle();
		set_rate('0);
		build_wav(1'b1, 2);
		send_wav(1'b1, wav_q.size(), 1'b0);
		wait_idle();
		set_rate('1);
		build_wav(1'b1, 2);
		send_wav(1'b1, wav_q.size(), 1'b1);
	endtask

	// The receiver holds off long while a long data chunk streams in, so the result
	// queue fills and the byte input must stall.
	task automatic test_backpressure();
		wait_idle();
		src_calm = 1'b1;
		snk_calm = 1'b1;
		hold_req = 1'b1;
		build_wav(1'b1, 48);
		send_wav(1'b1, wav_q.size(), 1'b0);
		src_calm = 1'b0;
		snk_calm = 1'b0;
	endtask

	// Mostly well-formed files with random content and random flaws, some noise, some
	// files cut short, and a new rate every few files.
	task automatic test_random_files();
		int unsigned start;
		int unsigned files;
		int unsigned flavor;
		start = bytes_sent;
		files = 0;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if (files % 6 == 5) begin
				wait_idle();
				case ($urandom_range(0, 3))
					0: set_rate(RATE_RESET);
					1: set_rate('0);
					2: set_rate('1);
					default: set_rate($urandom);
				endcase
			end
			src_calm = $urandom_range(0, 4) == 0;
			snk_calm = $urandom_range(0, 4) == 0;
			flavor = $urandom_range(0, 99);
			if (flavor < 5) begin
				wav_q.delete();
				repeat ($urandom_range(1, 16)) add_byte(rand_byte());
				send_wav(1'b1, wav_q.size(), 1'b1);
			end else if (flavor < 8) begin
				send_item(rand_byte(), 1'b1, 1'b1);
			end else begin
				build_wav(1'b0, flavor < 12 ? $urandom_range(16, 40) : $urandom_range(0, 6));
				if ($urandom_range(0, 9) == 0)
					send_wav(1'b1, $urandom_range(1, wav_q.size() - 1), 1'b1);
				else
					send_wav($urandom_range(0, 24) != 0, wav_q.size(),
						1'($urandom_range(0, 1)));
			end
			files++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		file_bytes.valid = 1'b0;
		file_bytes.data_byte = '0;
		file_bytes.start_of_file = 1'b0;
		file_bytes.end_of_file = 1'b0;
		samples.ready = 1'b0;
		rate_reg = RATE_RESET;
		clear_parser();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_no_start_mark();
		test_start_and_end();
		test_short_header();
		test_rate_extremes();
		test_backpressure();
		test_random_files();

		wait_idle();
		repeat (8) @(posedge clk);
		if (results_due.size() != 0) begin
			$display("%0t ns: %0d results never arrived", $time, results_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/wsp_pkg.sv
rtl/core/wsp_if.sv
rtl/core/wsp_cfg_regs.sv
rtl/core/wsp_parser_core.sv
rtl/core/wsp_out_queue.sv
rtl/core/wav_stream_parser.sv
verif/tb.sv
